[rtl/core/sme_pkg.sv]
// ----------------------------------------------------------------------------
// sme_pkg
// Opcode and status codes for the stack machine execute block.
// ----------------------------------------------------------------------------
package sme_pkg;

	localparam logic [4:0] OP_HLT   = 5'd0;
	localparam logic [4:0] OP_PUSH  = 5'd1;
	localparam logic [4:0] OP_POP   = 5'd2;
	localparam logic [4:0] OP_ADD   = 5'd3;
	localparam logic [4:0] OP_SUB   = 5'd4;
	localparam logic [4:0] OP_MUL   = 5'd5;
	localparam logic [4:0] OP_DIV   = 5'd6;
	localparam logic [4:0] OP_POW   = 5'd7;
	localparam logic [4:0] OP_SQRT  = 5'd8;
	localparam logic [4:0] OP_SIN   = 5'd9;
	localparam logic [4:0] OP_OUT   = 5'd10;
	localparam logic [4:0] OP_JMP   = 5'd11;
	localparam logic [4:0] OP_JB    = 5'd12;
	localparam logic [4:0] OP_JA    = 5'd13;
	localparam logic [4:0] OP_JE    = 5'd14;
	localparam logic [4:0] OP_JNE   = 5'd15;
	localparam logic [4:0] OP_JBE   = 5'd16;
	localparam logic [4:0] OP_JAE   = 5'd17;
	localparam logic [4:0] OP_SLEEP = 5'd18;
	localparam logic [4:0] OP_DRAW  = 5'd19;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_HALT   = 3'd1;
	localparam logic [2:0] ST_UNDEF  = 3'd2;
	localparam logic [2:0] ST_UNIMPL = 3'd3;
	localparam logic [2:0] ST_STACK  = 3'd4;
	localparam logic [2:0] ST_DIVZ   = 3'd5;

endpackage

[rtl/core/stack_machine_execute.sv]
// ----------------------------------------------------------------------------
// stack_machine_execute
// Executes one decoded stack machine instruction per input beat.
// ----------------------------------------------------------------------------
// channel | direction | fields
// in      | input     | func use_register use_constant use_memory register_index immediate
// out     | output    | next_ip status out_valid out_value
//
// After reset a pass clears data memory, one word per cycle until all MEMORY_WORDS
// words are cleared, with the input stalled. Each instruction passes S_RD, then
// S_MEM and S_EXEC once per read (push from memory, pop, out: one; add, sub, mul,
// div, pow, cond. jumps: two), S_DIV and S_OUT for div, S_POW for mul/pow, S_WB.
// One instruction at a time; write-back holds while the previous result beat waits.
// ----------------------------------------------------------------------------
module stack_machine_execute #(
	parameter int STACK_DEPTH    = 64,
	parameter int REGISTER_COUNT = 8,
	parameter int MEMORY_WORDS   = 1024,
	parameter int PROGRAM_WORDS  = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [4:0]         func,
	input  logic               use_register,
	input  logic               use_constant,
	input  logic               use_memory,
	input  logic [2:0]         register_index,
	input  logic signed [31:0] immediate,
	output logic               out_valid_beat,
	input  logic               out_stall,
	output logic [11:0]        next_ip,
	output logic [2:0]         status,
	output logic               out_valid,
	output logic signed [31:0] out_value
);

	localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int SDW = $clog2(STACK_DEPTH + 1);
	localparam int RAW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
	localparam int MAW = $clog2(MEMORY_WORDS);
	localparam int PAW = $clog2(PROGRAM_WORDS);
	localparam int IPW = (PAW > 12) ? PAW : 12;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_RD, S_MEM, S_EXEC, S_DIV, S_POW, S_WB, S_OUT
	} state_t;

	state_t state_q;
	logic [MAW-1:0] clr_q;
	logic [PAW-1:0] ip_q;
	logic [SDW-1:0] sd_q;
	logic [31:0] rf_q [REGISTER_COUNT];

	logic [31:0] stk_mem [STACK_DEPTH];
	logic [31:0] dat_mem [MEMORY_WORDS];
	logic [31:0] stk_rd_q, dat_rd_q;

	logic [4:0] func_q;
	logic ureg_q, ucon_q, umem_q;
	logic [RAW-1:0] ridx_q;
	logic [31:0] imm_q, a_q, b_q, c_q, addr_q;
	logic [2:0] st_q;
	logic [2:0] adv_q;
	logic jump_q;
	logic rd_b_q;
	logic [5:0] cnt_q;
	logic [31:0] rem_q, quo_q, ua_q, pw_q;
	logic neg_q, pw_mul_q;

	logic [31:0] rsel, opnd;
	assign rsel = rf_q[ridx_q];
	assign opnd = (ureg_q ? rsel : 32'd0) + (ucon_q ? imm_q : 32'd0);

	logic [31:0] ra;
	logic [32:0] rdiff;
	logic [63:0] pmul;
	assign ra    = {rem_q[30:0], quo_q[31]};
	assign rdiff = {1'b0, ra} - {1'b0, ua_q};
	assign pmul  = pw_q * (pw_mul_q ? b_q : pw_q);

	logic slt_ba, slt_ab;
	assign slt_ba = $signed(b_q) < $signed(a_q);
	assign slt_ab = $signed(a_q) < $signed(b_q);

	logic two_op;
	assign two_op = (func_q >= sme_pkg::OP_ADD && func_q <= sme_pkg::OP_POW)
		|| (func_q >= sme_pkg::OP_JB && func_q <= sme_pkg::OP_JAE);

	logic [RAW-1:0] ridx_in;
	assign ridx_in = RAW'(32'(register_index) % REGISTER_COUNT);

	logic wb_go;
	assign wb_go = (state_q == S_WB) && (!out_valid_beat || !out_stall);

	assign in_stall = (state_q != S_IDLE);

	logic stk_we, dat_we;
	logic [SAW-1:0] stk_wa, stk_ra;
	logic [MAW-1:0] dat_wa, dat_ra;
	logic [31:0] stk_wd, dat_wd;

	always_ff @(posedge clk) begin
		if (stk_we) stk_mem[stk_wa] <= stk_wd;
		stk_rd_q <= stk_mem[stk_ra];
		if (dat_we) dat_mem[dat_wa] <= dat_wd;
		dat_rd_q <= dat_mem[dat_ra];
	end

	logic [IPW-1:0] ip_adv;
	assign ip_adv = IPW'(ip_q) + IPW'(adv_q);

	always_comb begin
		stk_we = 1'b0;
		stk_wa = SAW'(sd_q);
		stk_wd = c_q;
		stk_ra = (rd_b_q || !two_op) ? SAW'(sd_q - SDW'(1)) : SAW'(sd_q - SDW'(2));
		dat_we = 1'b0;
		dat_wa = MAW'(addr_q);
		dat_wd = a_q;
		dat_ra = MAW'(addr_q);
		if (state_q == S_CLR) begin
			dat_we = 1'b1;
			dat_wa = clr_q;
			dat_wd = 32'd0;
		end else if (wb_go && st_q == sme_pkg::ST_OK) begin
			unique case (func_q)
				sme_pkg::OP_PUSH: stk_we = 1'b1;
				sme_pkg::OP_POP: dat_we = umem_q;
				sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV,
				sme_pkg::OP_POW: begin
					stk_we = 1'b1;
					stk_wa = SAW'(sd_q - SDW'(2));
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLR;
			clr_q          <= '0;
			ip_q           <= '0;
			sd_q           <= '0;
			out_valid_beat <= 1'b0;
			rd_b_q         <= 1'b0;
			for (int i = 0; i < REGISTER_COUNT; i++) rf_q[i] <= '0;
		end else begin
			if (out_valid_beat && !out_stall && !wb_go) out_valid_beat <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + MAW'(1);
					if (clr_q == MAW'(MEMORY_WORDS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						func_q <= func;
						ureg_q <= use_register;
						ucon_q <= use_constant;
						umem_q <= use_memory;
						ridx_q <= ridx_in;
						imm_q  <= immediate;
						rd_b_q <= 1'b0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					st_q   <= sme_pkg::ST_OK;
					jump_q <= 1'b0;
					adv_q  <= 3'd1;
					addr_q <= opnd;
					c_q    <= opnd;
					state_q <= S_WB;
					case (func_q)
						sme_pkg::OP_HLT: begin
							st_q <= sme_pkg::ST_HALT;
							adv_q <= 3'd0;
						end
						sme_pkg::OP_PUSH: begin
							adv_q <= 3'd2 + 3'(ureg_q) + 3'(ucon_q);
							if (sd_q >= SDW'(STACK_DEPTH)) st_q <= sme_pkg::ST_STACK;
							else if (umem_q) state_q <= S_MEM;
						end
						sme_pkg::OP_POP: begin
							adv_q <= 3'd2 + 3'(ureg_q) + 3'(umem_q & ucon_q);
							if (sd_q < SDW'(1)) st_q <= sme_pkg::ST_STACK;
							else state_q <= S_MEM;
						end
						sme_pkg::OP_OUT: begin
							if (sd_q < SDW'(1)) st_q <= sme_pkg::ST_STACK;
							else state_q <= S_MEM;
						end
						sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV,
						sme_pkg::OP_POW, sme_pkg::OP_JB, sme_pkg::OP_JA, sme_pkg::OP_JE,
						sme_pkg::OP_JNE, sme_pkg::OP_JBE, sme_pkg::OP_JAE: begin
							if (func_q >= sme_pkg::OP_JB) adv_q <= 3'd2;
							if (sd_q < SDW'(2)) st_q <= sme_pkg::ST_STACK;
							else begin
								rd_b_q <= 1'b1;
								state_q <= S_MEM;
							end
						end
						sme_pkg::OP_SQRT, sme_pkg::OP_SIN: st_q <= sme_pkg::ST_UNIMPL;
						sme_pkg::OP_JMP: jump_q <= 1'b1;
						sme_pkg::OP_SLEEP: adv_q <= 3'd2;
						sme_pkg::OP_DRAW: adv_q <= 3'd3;
						default: st_q <= sme_pkg::ST_UNDEF;
					endcase
				end
				S_MEM: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (rd_b_q) begin
						a_q <= stk_rd_q;
						rd_b_q <= 1'b0;
						state_q <= S_MEM;
					end else begin
						state_q <= S_WB;
						case (func_q)
							sme_pkg::OP_PUSH: c_q <= dat_rd_q;
							sme_pkg::OP_POP, sme_pkg::OP_OUT: a_q <= stk_rd_q;
							sme_pkg::OP_ADD: c_q <= stk_rd_q + a_q;
							sme_pkg::OP_SUB: c_q <= stk_rd_q - a_q;
							sme_pkg::OP_MUL, sme_pkg::OP_POW,
							sme_pkg::OP_JB, sme_pkg::OP_JA, sme_pkg::OP_JE,
							sme_pkg::OP_JNE, sme_pkg::OP_JBE, sme_pkg::OP_JAE: begin
								b_q <= stk_rd_q;
								if (func_q == sme_pkg::OP_MUL || func_q == sme_pkg::OP_POW) begin
									pw_q <= (func_q == sme_pkg::OP_MUL) ? a_q : 32'd1;
									pw_mul_q <= (func_q == sme_pkg::OP_MUL);
									cnt_q <= 6'd31;
									state_q <= S_POW;
								end
							end
							sme_pkg::OP_DIV: begin
								b_q <= stk_rd_q;
								if (a_q == 32'd0) st_q <= sme_pkg::ST_DIVZ;
								else begin
									quo_q <= stk_rd_q[31] ? 32'd0 - stk_rd_q : stk_rd_q;
									ua_q  <= a_q[31] ? 32'd0 - a_q : a_q;
									neg_q <= stk_rd_q[31] ^ a_q[31];
									rem_q <= 32'd0;
									cnt_q <= 6'd31;
									state_q <= S_DIV;
								end
							end
							default: ;
						endcase
					end
				end
				S_DIV: begin
					if (!rdiff[32]) begin
						rem_q <= rdiff[31:0];
						quo_q <= {quo_q[30:0], 1'b1};
					end else begin
						rem_q <= ra;
						quo_q <= {quo_q[30:0], 1'b0};
					end
					if (cnt_q == 6'd0) state_q <= S_OUT;
					cnt_q <= cnt_q - 6'd1;
				end
				S_POW: begin
					if (func_q == sme_pkg::OP_MUL) begin
						c_q <= pmul[31:0];
						state_q <= S_WB;
					end else if (a_q[31]) begin
						state_q <= S_WB;
						if (b_q == 32'd1) c_q <= 32'd1;
						else if (b_q == 32'hFFFF_FFFF) c_q <= a_q[0] ? 32'hFFFF_FFFF : 32'd1;
						else begin
							c_q <= 32'd0;
							if (b_q == 32'd0) st_q <= sme_pkg::ST_DIVZ;
						end
					end else if (!pw_mul_q) begin
						pw_q <= pmul[31:0];
						pw_mul_q <= a_q[cnt_q[4:0]];
						if (!a_q[cnt_q[4:0]]) begin
							if (cnt_q == 6'd0) begin
								c_q <= pmul[31:0];
								state_q <= S_WB;
							end
							cnt_q <= cnt_q - 6'd1;
						end
					end else begin
						pw_q <= pmul[31:0];
						pw_mul_q <= 1'b0;
						if (cnt_q == 6'd0) begin
							c_q <= pmul[31:0];
							state_q <= S_WB;
						end
						cnt_q <= cnt_q - 6'd1;
					end
				end
				S_OUT: begin
					c_q <= neg_q ? 32'd0 - quo_q : quo_q;
					state_q <= S_WB;
				end
				S_WB: begin
					logic take;
					take = jump_q;
					if (wb_go) begin
						if (st_q == sme_pkg::ST_OK) begin
							unique case (func_q)
								sme_pkg::OP_PUSH: sd_q <= sd_q + SDW'(1);
								sme_pkg::OP_POP: begin
									sd_q <= sd_q - SDW'(1);
									if (!umem_q && ureg_q) rf_q[ridx_q] <= a_q;
								end
								sme_pkg::OP_OUT: sd_q <= sd_q - SDW'(1);
								sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV,
								sme_pkg::OP_POW: sd_q <= sd_q - SDW'(1);
								sme_pkg::OP_JB: begin sd_q <= sd_q - SDW'(2); take = slt_ba; end
								sme_pkg::OP_JA: begin sd_q <= sd_q - SDW'(2); take = slt_ab; end
								sme_pkg::OP_JE: begin sd_q <= sd_q - SDW'(2); take = a_q == b_q; end
								sme_pkg::OP_JNE: begin sd_q <= sd_q - SDW'(2); take = a_q != b_q; end
								sme_pkg::OP_JBE: begin sd_q <= sd_q - SDW'(2); take = !slt_ab; end
								sme_pkg::OP_JAE: begin sd_q <= sd_q - SDW'(2); take = !slt_ba; end
								default: ;
							endcase
						end
						if (take) begin
							ip_q <= PAW'(imm_q);
							next_ip <= 12'(PAW'(imm_q));
						end else begin
							ip_q <= PAW'(ip_adv);
							next_ip <= 12'(PAW'(ip_adv));
						end
						status <= st_q;
						out_valid <= (st_q == sme_pkg::ST_OK) && (func_q == sme_pkg::OP_OUT);
						out_value <= ((st_q == sme_pkg::ST_OK) && (func_q == sme_pkg::OP_OUT))
							? a_q : 32'd0;
						out_valid_beat <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
